/* rtl/core/uv_sphere_vertex_generator_top_macros.svh */
// Assertion macros for the sphere vertex generator.
// Expect clk and rst_n in the scope of use.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define USVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define USVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/usvg_pkg.sv */
// Shared types, constants and the arctangent table of the sphere vertex generator.
// No dependencies.
`default_nettype none
package usvg_pkg;

  localparam int PREC_W     = 9;
  localparam int IDX_W      = 9;
  localparam int TEX_W      = 17;
  localparam int VTX_W      = 17;
  localparam int POS_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int PREC_RESET = 48;
  localparam logic [TEX_W-1:0] TEX_MAX = 17'h1FFFF;

  localparam int DIV_NUM_W           = 41;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = (DIV_NUM_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int DIV_LAT             = DIV_STAGES + 1;
  localparam int AZ_TEX_STEPS        = 25;
  localparam int POL_TEX_STEPS       = 26;

  localparam int CORDIC_STEPS     = 28;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CORDIC_LAT       = CORDIC_STAGES + 1;
  localparam int CORDIC_XW        = 34;
  localparam int CORDIC_ZW        = 32;
  localparam int CS_W             = 32;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int POST_LAT = 3;
  localparam int PIPE_LAT = DIV_LAT + CORDIC_LAT + POST_LAT;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [VTX_W-1:0] vertex_number;
    logic             quad_valid;
    logic [VTX_W-1:0] corner_b;
    logic [VTX_W-1:0] corner_c;
    logic [VTX_W-1:0] corner_d;
  } usvg_side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    usvg_side_t              side;
  } usvg_res_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] a;
    unique case (k)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/usvg_in_if.sv */
// Input channel: one grid point per transaction.
// Depends on usvg_pkg.
`default_nettype none
interface usvg_in_if;
  logic                        valid;
  logic                        ready;
  logic [usvg_pkg::IDX_W-1:0]  ring_index;
  logic [usvg_pkg::IDX_W-1:0]  segment_index;

  modport source (output valid, output ring_index, output segment_index, input ready);
  modport sink   (input valid, input ring_index, input segment_index, output ready);
endinterface
`default_nettype wire

/* rtl/core/usvg_out_if.sv */
// Result channel: one vertex per transaction.
// Depends on usvg_pkg.
`default_nettype none
interface usvg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [usvg_pkg::POS_W-1:0] pos_x;
  logic signed [usvg_pkg::POS_W-1:0] pos_y;
  logic signed [usvg_pkg::POS_W-1:0] pos_z;
  logic [usvg_pkg::TEX_W-1:0]        tex_u;
  logic [usvg_pkg::TEX_W-1:0]        tex_v;
  logic [usvg_pkg::VTX_W-1:0]        vertex_number;
  logic                              quad_valid;
  logic [usvg_pkg::VTX_W-1:0]        corner_b;
  logic [usvg_pkg::VTX_W-1:0]        corner_c;
  logic [usvg_pkg::VTX_W-1:0]        corner_d;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output tex_u,
                  output tex_v, output vertex_number, output quad_valid, output corner_b,
                  output corner_c, output corner_d, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input tex_u,
                  input tex_v, input vertex_number, input quad_valid, input corner_b,
                  input corner_c, input corner_d, output ready);
endinterface
`default_nettype wire

/* rtl/core/usvg_div.sv */
// Pipelined restoring divider: rounded phase and texture coordinate over precision.
// Depends on usvg_pkg.
`default_nettype none
module usvg_div #(
  parameter int TEX_STEPS = 25
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [usvg_pkg::PREC_W-1:0]     prec,
  input  wire logic [usvg_pkg::DIV_NUM_W-1:0]  num,
  output logic [usvg_pkg::PHASE_W-1:0]         phase,
  output logic [usvg_pkg::TEX_W-1:0]           tex
);
  localparam int NW = usvg_pkg::DIV_NUM_W;
  localparam int NS = usvg_pkg::DIV_STAGES;
  localparam int SP = usvg_pkg::DIV_STEPS_PER_STAGE;
  localparam int PW = usvg_pkg::PREC_W;
  localparam int TW = TEX_STEPS;

  logic [NW-1:0] num_r [NS];
  logic [NW-1:0] num_in [NS];
  logic [NW-1:0] quo_r [NS];
  logic [NW-1:0] quo_in [NS];
  logic [NW-1:0] quo_nxt [NS];
  logic [PW-1:0] rem_r [NS];
  logic [PW-1:0] rem_in [NS];
  logic [PW-1:0] rem_nxt [NS];
  logic [PW-1:0] tr_r [NS];
  logic [PW-1:0] tr_in [NS];
  logic [PW-1:0] tr_nxt [NS];
  logic [TW-1:0] tq_r [NS];
  logic [TW-1:0] tq_in [NS];
  logic [TW-1:0] tq_nxt [NS];
  logic [PW:0]   cand;
  logic [PW:0]   prec_x;
  logic [PW-1:0] half_up;
  logic [TW:0]   tex_sum;
  logic [usvg_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [usvg_pkg::TEX_W-1:0]   tex_r, tex_nxt;

  assign prec_x  = {1'b0, prec};
  assign half_up = prec - (prec >> 1);

  always_comb begin
    num_in[0] = num;
    quo_in[0] = '0;
    rem_in[0] = '0;
    tr_in[0]  = '0;
    tq_in[0]  = '0;
    for (int s = 1; s < NS; s++) begin
      num_in[s] = num_r[s-1];
      quo_in[s] = quo_r[s-1];
      rem_in[s] = rem_r[s-1];
      tr_in[s]  = tr_r[s-1];
      tq_in[s]  = tq_r[s-1];
    end
  end

  always_comb begin
    cand = '0;
    for (int s = 0; s < NS; s++) begin
      rem_nxt[s] = rem_in[s];
      quo_nxt[s] = quo_in[s];
      tq_nxt[s]  = tq_in[s];
      tr_nxt[s]  = tr_in[s];
      for (int t = 0; t < SP; t++) begin
        if (s * SP + t < NW) begin
          cand = {rem_nxt[s], num_in[s][NW-1-(s*SP+t)]};
          if (cand >= prec_x) begin
            rem_nxt[s] = PW'(cand - prec_x);
            quo_nxt[s] = {quo_nxt[s][NW-2:0], 1'b1};
          end else begin
            rem_nxt[s] = cand[PW-1:0];
            quo_nxt[s] = {quo_nxt[s][NW-2:0], 1'b0};
          end
          if (s * SP + t == TW - 1) begin
            tq_nxt[s] = quo_nxt[s][TW-1:0];
            tr_nxt[s] = rem_nxt[s];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        num_r[s] <= num_in[s];
        quo_r[s] <= quo_nxt[s];
        rem_r[s] <= rem_nxt[s];
        tq_r[s]  <= tq_nxt[s];
        tr_r[s]  <= tr_nxt[s];
      end
    end
  end

  always_comb begin
    phase_nxt = quo_r[NS-1][usvg_pkg::PHASE_W-1:0]
              + usvg_pkg::PHASE_W'(rem_r[NS-1] >= half_up);
    tex_sum   = {1'b0, tq_r[NS-1]} + (TW+1)'(tr_r[NS-1] >= half_up);
    tex_nxt   = (tex_sum > (TW+1)'(usvg_pkg::TEX_MAX)) ? usvg_pkg::TEX_MAX
              : tex_sum[usvg_pkg::TEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_nxt;
      tex_r   <= tex_nxt;
    end
  end

  assign phase = phase_r;
  assign tex   = tex_r;
endmodule
`default_nettype wire

/* rtl/core/usvg_cordic.sv */
// Pipelined rotation CORDIC: sine and cosine of a full-turn phase in Q2.30.
// Depends on usvg_pkg.
`default_nettype none
module usvg_cordic (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [usvg_pkg::PHASE_W-1:0]        phase,
  output logic signed [usvg_pkg::CS_W-1:0]         cos_o,
  output logic signed [usvg_pkg::CS_W-1:0]         sin_o
);
  localparam int NS = usvg_pkg::CORDIC_STAGES;
  localparam int SP = usvg_pkg::CORDIC_PER_STAGE;
  localparam int XW = usvg_pkg::CORDIC_XW;
  localparam int ZW = usvg_pkg::CORDIC_ZW;
  localparam int CW = usvg_pkg::CS_W;

  logic signed [XW-1:0] x_r [NS];
  logic signed [XW-1:0] x_in [NS];
  logic signed [XW-1:0] x_nxt [NS];
  logic signed [XW-1:0] y_r [NS];
  logic signed [XW-1:0] y_in [NS];
  logic signed [XW-1:0] y_nxt [NS];
  logic signed [ZW-1:0] z_r [NS];
  logic signed [ZW-1:0] z_in [NS];
  logic signed [ZW-1:0] z_nxt [NS];
  logic [1:0]           q_r [NS];
  logic [1:0]           q_in [NS];
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [CW-1:0] cos_r, sin_r;

  always_comb begin
    x_in[0] = usvg_pkg::CORDIC_GAIN;
    y_in[0] = '0;
    z_in[0] = signed'({2'b00, phase[usvg_pkg::PHASE_W-3:0]});
    q_in[0] = phase[usvg_pkg::PHASE_W-1:usvg_pkg::PHASE_W-2];
    for (int s = 1; s < NS; s++) begin
      x_in[s] = x_r[s-1];
      y_in[s] = y_r[s-1];
      z_in[s] = z_r[s-1];
      q_in[s] = q_r[s-1];
    end
  end

  always_comb begin
    dx = '0;
    dy = '0;
    at = '0;
    for (int s = 0; s < NS; s++) begin
      x_nxt[s] = x_in[s];
      y_nxt[s] = y_in[s];
      z_nxt[s] = z_in[s];
      for (int t = 0; t < SP; t++) begin
        dx = y_nxt[s] >>> (s * SP + t);
        dy = x_nxt[s] >>> (s * SP + t);
        at = signed'(usvg_pkg::atan_turn(5'(s * SP + t)));
        if (!z_nxt[s][ZW-1]) begin
          x_nxt[s] = x_nxt[s] - dx;
          y_nxt[s] = y_nxt[s] + dy;
          z_nxt[s] = z_nxt[s] - at;
        end else begin
          x_nxt[s] = x_nxt[s] + dx;
          y_nxt[s] = y_nxt[s] - dy;
          z_nxt[s] = z_nxt[s] + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        x_r[s] <= x_nxt[s];
        y_r[s] <= y_nxt[s];
        z_r[s] <= z_nxt[s];
        q_r[s] <= q_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (q_r[NS-1])
        usvg_pkg::QUAD_0: begin
          cos_r <= CW'(x_r[NS-1]);
          sin_r <= CW'(y_r[NS-1]);
        end
        usvg_pkg::QUAD_1: begin
          cos_r <= CW'(-y_r[NS-1]);
          sin_r <= CW'(x_r[NS-1]);
        end
        usvg_pkg::QUAD_2: begin
          cos_r <= CW'(-x_r[NS-1]);
          sin_r <= CW'(-y_r[NS-1]);
        end
        usvg_pkg::QUAD_3: begin
          cos_r <= CW'(y_r[NS-1]);
          sin_r <= CW'(-x_r[NS-1]);
        end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule
`default_nettype wire

/* rtl/core/usvg_ofifo.sv */
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on usvg_pkg.
`default_nettype none
module usvg_ofifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire usvg_pkg::usvg_res_t push_data,
  output logic                     full,
  input  wire logic                pop_ready,
  output logic                     pop_valid,
  output usvg_pkg::usvg_res_t      pop_data
);
  usvg_pkg::usvg_res_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/uv_sphere_vertex_generator_top.sv */
// Throughput: one vertex per cycle, set by the pipelined dividers and CORDIC units,
// while the output buffer is not full; a full buffer stalls the whole pipeline.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst_n low, synchronous) empties the pipeline and buffer, precision returns to 48.
// Depends on usvg_pkg, usvg_in_if, usvg_out_if, usvg_div, usvg_cordic, usvg_ofifo.
`default_nettype none
`include "uv_sphere_vertex_generator_top_macros.svh"
module uv_sphere_vertex_generator_top #(
  parameter int MAX_PREC  = 256,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  usvg_in_if.sink                          in_if,
  usvg_out_if.source                       out_if,
  input  wire logic                        cfg_we,
  input  wire logic [usvg_pkg::PREC_W-1:0] cfg_wdata
);
  localparam int PW   = usvg_pkg::PREC_W;
  localparam int CW   = usvg_pkg::CS_W;
  localparam int PL   = usvg_pkg::PIPE_LAT;
  localparam int TDLY = usvg_pkg::CORDIC_LAT + usvg_pkg::POST_LAT;
  localparam int SH_XZ = 60 - FRAC_BITS;
  localparam int SH_Y  = 30 - FRAC_BITS;
  localparam logic [63:0] LIM = 64'd1 << FRAC_BITS;

  function automatic logic [PW-1:0] clamp_prec(input logic [PW-1:0] v);
    logic [PW-1:0] r;
    priority if (v == '0) begin
      r = PW'(1);
    end else if (int'(v) > MAX_PREC) begin
      r = PW'(MAX_PREC);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [usvg_pkg::POS_W-1:0] to_pos(input logic signed [63:0] v,
                                                          input logic neg_out,
                                                          input int sh);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    if (sh > 0) begin
      r = (m + (64'd1 << (sh - 1))) >> sh;
    end else begin
      r = m;
    end
    if (r > LIM) begin
      r = LIM;
    end
    return (v[63] ^ neg_out) ? usvg_pkg::POS_W'(64'd0 - r) : usvg_pkg::POS_W'(r);
  endfunction

  logic [PW-1:0] prec_r;
  logic          adv, accept, fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= clamp_prec(PW'(usvg_pkg::PREC_RESET));
    end else if (cfg_we) begin
      prec_r <= clamp_prec(cfg_wdata);
    end
  end

  assign adv         = !fifo_full;
  assign in_if.ready = adv;
  assign accept      = in_if.valid && adv;

  // quad corner indices
  logic [PW:0]   prec_p1;
  logic [18:0]   a_full, c_full;
  logic          quad;
  usvg_pkg::usvg_side_t side_nxt;

  always_comb begin
    prec_p1 = {1'b0, prec_r} + (PW+1)'(1);
    a_full  = 19'(in_if.ring_index) * 19'(prec_p1) + 19'(in_if.segment_index);
    c_full  = a_full + 19'(prec_p1);
    quad    = (in_if.ring_index < prec_r) && (in_if.segment_index < prec_r);
    side_nxt.vertex_number = a_full[16:0];
    side_nxt.quad_valid    = quad;
    side_nxt.corner_b      = quad ? a_full[16:0] + 17'd1 : '0;
    side_nxt.corner_c      = quad ? c_full[16:0] : '0;
    side_nxt.corner_d      = quad ? c_full[16:0] + 17'd1 : '0;
  end

  logic                 vld_r [PL];
  usvg_pkg::usvg_side_t side_r [PL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PL; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= accept;
      for (int s = 1; s < PL; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < PL; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  logic [usvg_pkg::PHASE_W-1:0] az_phase, pol_phase;
  logic [usvg_pkg::TEX_W-1:0]   tex_u_d, tex_v_d;

  usvg_div #(.TEX_STEPS(usvg_pkg::AZ_TEX_STEPS)) u_div_az (
    .clk   (clk),
    .en    (adv),
    .prec  (prec_r),
    .num   ({in_if.segment_index, 32'd0}),
    .phase (az_phase),
    .tex   (tex_u_d)
  );

  usvg_div #(.TEX_STEPS(usvg_pkg::POL_TEX_STEPS)) u_div_pol (
    .clk   (clk),
    .en    (adv),
    .prec  (prec_r),
    .num   ({1'b0, in_if.ring_index, 31'd0}),
    .phase (pol_phase),
    .tex   (tex_v_d)
  );

  logic [usvg_pkg::TEX_W-1:0] texu_r [TDLY];
  logic [usvg_pkg::TEX_W-1:0] texv_r [TDLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      texu_r[0] <= tex_u_d;
      texv_r[0] <= tex_v_d;
      for (int s = 1; s < TDLY; s++) begin
        texu_r[s] <= texu_r[s-1];
        texv_r[s] <= texv_r[s-1];
      end
    end
  end

  logic signed [CW-1:0] ca, sa, cp, sp;

  usvg_cordic u_cordic_az (
    .clk   (clk),
    .en    (adv),
    .phase (az_phase),
    .cos_o (ca),
    .sin_o (sa)
  );

  usvg_cordic u_cordic_pol (
    .clk   (clk),
    .en    (adv),
    .phase (pol_phase),
    .cos_o (cp),
    .sin_o (sp)
  );

  logic signed [CW-1:0]   ca_r, sa_r, cp_r, spa_r, cp1_r;
  logic signed [2*CW-1:0] px_r, pz_r;
  logic signed [usvg_pkg::POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_r    <= ca;
      sa_r    <= sa;
      cp_r    <= cp;
      spa_r   <= sp[CW-1] ? -sp : sp;
      px_r    <= ca_r * spa_r;
      pz_r    <= sa_r * spa_r;
      cp1_r   <= cp_r;
      pos_x_r <= to_pos(px_r, 1'b1, SH_XZ);
      pos_z_r <= to_pos(pz_r, 1'b0, SH_XZ);
      pos_y_r <= to_pos({{CW{cp1_r[CW-1]}}, cp1_r}, 1'b1, SH_Y);
    end
  end

  usvg_pkg::usvg_res_t res, res_out;
  logic                push;

  always_comb begin
    res.pos_x = pos_x_r;
    res.pos_y = pos_y_r;
    res.pos_z = pos_z_r;
    res.tex_u = texu_r[TDLY-1];
    res.tex_v = texv_r[TDLY-1];
    res.side  = side_r[PL-1];
  end

  assign push = adv && vld_r[PL-1];

  usvg_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (fifo_full),
    .pop_ready (out_if.ready),
    .pop_valid (out_if.valid),
    .pop_data  (res_out)
  );

  assign out_if.pos_x         = res_out.pos_x;
  assign out_if.pos_y         = res_out.pos_y;
  assign out_if.pos_z         = res_out.pos_z;
  assign out_if.tex_u         = res_out.tex_u;
  assign out_if.tex_v         = res_out.tex_v;
  assign out_if.vertex_number = res_out.side.vertex_number;
  assign out_if.quad_valid    = res_out.side.quad_valid;
  assign out_if.corner_b      = res_out.side.corner_b;
  assign out_if.corner_c      = res_out.side.corner_c;
  assign out_if.corner_d      = res_out.side.corner_d;

  `USVG_ASSERT_NOW(a_no_quad_zero, out_if.valid && !out_if.quad_valid, out_if.corner_b == '0 && out_if.corner_c == '0 && out_if.corner_d == '0, "corners set without a quad")
  `USVG_ASSERT_NOW(a_corner_b, out_if.valid && out_if.quad_valid, out_if.corner_b == 17'(out_if.vertex_number + 17'd1), "corner b is not a plus one")
  `USVG_ASSERT_NEXT(a_stall_hold, vld_r[PL-1] && !adv, vld_r[PL-1], "stalled item dropped")
  `USVG_ASSERT_NEXT(a_prec_range, cfg_we, prec_r != '0 && int'(prec_r) <= MAX_PREC, "precision out of range")
endmodule
`default_nettype wire
